// ===== sv/intel_hex_record_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Intel HEX record parser assertion macros
// Implication and next-cycle checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_PARSER_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define IHEX_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ihex assertion failed");
`define IHEX_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ihex assertion failed");
`else
`define IHEX_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define IHEX_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record parser package
// Item types, record phases, result kinds and error codes.
// ----------------------------------------------------------------------------
package ihex_pkg;

   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;

   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_EOF  = 8'h01;
   localparam logic [7:0] REC_EXT  = 8'h04;
   localparam logic [7:0] REC_SYM  = 8'hfe;

   typedef enum logic [2:0] {
      PH_START,
      PH_LEN,
      PH_ADDR,
      PH_TYPE,
      PH_DATA,
      PH_CSUM,
      PH_EOL,
      PH_HALT
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_ERROR = 2'd1,
      KIND_OK    = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ERR_NONE       = 4'd0,
      ERR_START      = 4'd1,
      ERR_INCOMPLETE = 4'd2,
      ERR_CHECKSUM   = 4'd3,
      ERR_BACKWARD   = 4'd4,
      ERR_DUP_EOF    = 4'd5,
      ERR_TYPE       = 4'd6,
      ERR_NO_EOF     = 4'd7,
      ERR_NONHEX     = 4'd8
   } err_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [31:0] byte_address;
      logic [31:0] fill_count;
      err_type     error_code;
   } rsp_type;

endpackage

// ===== sv/ihex_parse_core.sv =====
// ----------------------------------------------------------------------------
// Intel HEX parse core
// Record state and single-pass decode of one character into at most one item.
// ----------------------------------------------------------------------------
`include "intel_hex_record_parser_macros.svh"

module ihex_parse_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  ihex_pkg::req_type item,
   input  logic             check_checksum,
   output logic             emit,
   output ihex_pkg::rsp_type result
);
   import ihex_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  nibble_ff, nibble_in;
   logic        half_ff, half_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] low_ff, low_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] high_ff, high_in;
   logic [15:0] ext_ff, ext_in;
   logic [31:0] cur_ff, cur_in;
   logic [31:0] last_ff, last_in;
   logic [7:0]  sum_ff, sum_in;
   logic        eof_ff, eof_in;

   logic [4:0]  hex;
   logic [7:0]  byte_val;
   logic [7:0]  count_inc;
   logic [31:0] hole;
   logic [31:0] base_addr;
   err_type     err;

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

   always_comb begin
      phase_in  = phase_ff;
      nibble_in = nibble_ff;
      half_in   = half_ff;
      count_in  = count_ff;
      length_in = length_ff;
      low_in    = low_ff;
      type_in   = type_ff;
      high_in   = high_ff;
      ext_in    = ext_ff;
      cur_in    = cur_ff;
      last_in   = last_ff;
      sum_in    = sum_ff;
      eof_in    = eof_ff;
      emit      = 1'b0;
      result    = '0;
      err       = ERR_NONE;
      hex       = hex_decode(item.ch);
      byte_val  = {nibble_ff, hex[3:0]};
      count_inc = count_ff + 8'd1;
      hole      = cur_ff - last_ff;
      base_addr = {high_ff, low_ff};

      if (phase_ff != PH_HALT) begin
         if (phase_ff == PH_START || phase_ff == PH_EOL) begin
            if (item.ch == CHAR_COLON) begin
               phase_in = PH_LEN;
               half_in  = 1'b0;
               count_in = 8'd0;
               sum_in   = 8'd0;
            end else if (!(phase_ff == PH_EOL &&
                           (item.ch == CHAR_LF || item.ch == CHAR_CR))) begin
               err = ERR_START;
            end
         end else if (!hex[4]) begin
            err = ERR_NONHEX;
         end else if (!half_ff) begin
            nibble_in = hex[3:0];
            half_in   = 1'b1;
         end else begin
            half_in = 1'b0;
            sum_in  = sum_ff + byte_val;
            case (phase_ff)
               PH_LEN: begin
                  length_in = byte_val;
                  count_in  = 8'd0;
                  phase_in  = PH_ADDR;
               end
               PH_ADDR: begin
                  if (count_ff == 8'd0) begin
                     low_in   = {byte_val, 8'd0};
                     count_in = 8'd1;
                  end else begin
                     low_in   = {low_ff[15:8], byte_val};
                     phase_in = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  type_in  = byte_val;
                  count_in = 8'd0;
                  ext_in   = 16'd0;
                  if (byte_val == REC_DATA) begin
                     cur_in = base_addr;
                     if (base_addr < last_ff) begin
                        err = ERR_BACKWARD;
                     end
                  end
                  phase_in = (length_ff != 8'd0) ? PH_DATA : PH_CSUM;
               end
               PH_DATA: begin
                  if (type_ff == REC_DATA) begin
                     emit                = 1'b1;
                     result.kind         = KIND_DATA;
                     result.data_byte    = byte_val;
                     result.byte_address = cur_ff;
                     result.fill_count   = (last_ff != 32'd0 && hole > 32'd1) ?
                                           hole - 32'd1 : 32'd0;
                     last_in             = cur_ff;
                     cur_in              = cur_ff + 32'd1;
                  end else if (type_ff == REC_EXT) begin
                     if (count_ff == 8'd0) begin
                        ext_in = {byte_val, 8'd0};
                     end else if (count_ff == 8'd1) begin
                        ext_in = {ext_ff[15:8], byte_val};
                     end
                  end
                  count_in = count_inc;
                  if (count_inc == length_ff) begin
                     phase_in = PH_CSUM;
                  end
               end
               PH_CSUM: begin
                  phase_in = PH_EOL;
                  if (check_checksum && sum_in != 8'd0) begin
                     err = ERR_CHECKSUM;
                  end else begin
                     case (type_ff)
                        REC_DATA: begin
                        end
                        REC_EOF: begin
                           if (eof_ff) begin
                              err = ERR_DUP_EOF;
                           end else begin
                              eof_in = 1'b1;
                           end
                        end
                        REC_EXT: begin
                           high_in = ext_ff;
                           cur_in  = {ext_ff, low_ff};
                        end
                        REC_SYM: begin
                           cur_in = base_addr;
                        end
                        default: begin
                           if (!eof_ff) begin
                              err = ERR_TYPE;
                           end
                        end
                     endcase
                  end
               end
               default: begin
               end
            endcase
         end

         if (err == ERR_NONE && item.end_of_input) begin
            if (phase_in != PH_EOL) begin
               err = ERR_INCOMPLETE;
            end else if (!eof_in) begin
               err = ERR_NO_EOF;
            end else begin
               emit        = 1'b1;
               result      = '0;
               result.kind = KIND_OK;
               phase_in    = PH_HALT;
            end
         end

         if (err != ERR_NONE) begin
            emit              = 1'b1;
            result            = '0;
            result.kind       = KIND_ERROR;
            result.error_code = err;
            phase_in          = PH_HALT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         nibble_ff <= 4'd0;
         half_ff   <= 1'b0;
         count_ff  <= 8'd0;
         length_ff <= 8'd0;
         low_ff    <= 16'd0;
         type_ff   <= 8'd0;
         high_ff   <= 16'd0;
         ext_ff    <= 16'd0;
         cur_ff    <= 32'd0;
         last_ff   <= 32'd0;
         sum_ff    <= 8'd0;
         eof_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         nibble_ff <= nibble_in;
         half_ff   <= half_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         low_ff    <= low_in;
         type_ff   <= type_in;
         high_ff   <= high_in;
         ext_ff    <= ext_in;
         cur_ff    <= cur_in;
         last_ff   <= last_in;
         sum_ff    <= sum_in;
         eof_ff    <= eof_in;
      end
   end

   `IHEX_ASSERT_IMP(a_halt_silent, clock, reset, phase_ff == PH_HALT, !emit)
   `IHEX_ASSERT_NXT(a_final_halts, clock, reset, step && emit && result.kind != KIND_DATA, phase_ff == PH_HALT)
   `IHEX_ASSERT_NXT(a_last_tracks, clock, reset, step && emit && result.kind == KIND_DATA, last_ff == $past(result.byte_address))
   `IHEX_ASSERT_IMP(a_err_coded, clock, reset, emit && result.kind == KIND_ERROR, result.error_code != ERR_NONE)

endmodule

// ===== sv/intel_hex_record_parser.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record parser
// Input register, parse core and result register for an I32HEX byte stream.
// ----------------------------------------------------------------------------
// One ASCII character is taken per cycle, back to back, unless an unread
// result stalls it; it waits in the input register, its result item in the
// result register. The single parse stage between them sets the rate and
// updates the record state once per character. After an error or the final
// status item the block takes characters but gives nothing until reset.
`include "intel_hex_record_parser_macros.svh"

module intel_hex_record_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ihex_pkg::req_type  req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ihex_pkg::rsp_type  rsp_item,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import ihex_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   logic    check_ff;
   logic    advance;
   logic    emit;
   rsp_type result;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = (advance && emit) || (out_valid_ff && !rsp_ready);
   assign rsp_valid    = out_valid_ff;
   assign rsp_item     = out_item_ff;

   ihex_parse_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .item           (in_item_ff),
      .check_checksum (check_ff),
      .emit           (emit),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         check_ff     <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            check_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance && emit) begin
         out_item_ff <= result;
      end
   end

   `IHEX_ASSERT_NXT(a_result_lands, clock, reset, advance && emit, out_valid_ff && out_item_ff == $past(result))
   `IHEX_ASSERT_IMP(a_no_overrun, clock, reset, out_valid_ff && !rsp_ready, !advance)
   `IHEX_ASSERT_NXT(a_input_drains, clock, reset, in_valid_ff && !out_valid_ff, !in_valid_ff || $past(req_valid && req_ready))

endmodule

// ===== tb/sv/tb_intel_hex_record_parser.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record parser testbench
// Streams whole hex files one character at a time: short directed records,
// then random records under three idling patterns with the checksum test
// on, off (some bad sums) and on, then one randomly chosen way for the file
// to end. Every result item is checked against a cycle-free decoder.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_parser;
   import ihex_pkg::*;

   typedef logic [7:0] byte_list[$];

   typedef enum int {
      FIN_OK,
      FIN_START,
      FIN_INCOMPLETE,
      FIN_CHECKSUM,
      FIN_BACKWARD,
      FIN_DUP_EOF,
      FIN_TYPE,
      FIN_NO_EOF,
      FIN_NONHEX
   } ending_type;

   localparam int CYCLE_LIMIT = 200000;

   class hex_decoder;
      rsp_type     pending_results[$];
      int unsigned fails;
      bit          check_on;
      phase_type   phase;
      logic [3:0]  nib;
      bit          half;
      logic [7:0]  count;
      logic [7:0]  rec_len;
      logic [7:0]  rec_type;
      logic [7:0]  sum;
      logic [15:0] low_addr;
      logic [15:0] high_addr;
      logic [15:0] ext_word;
      logic [31:0] cur_addr;
      logic [31:0] last_addr;
      bit          seen_eof;
      rsp_type     data_out;
      bit          data_hit;

      function new();
         check_on  = 1'b1;
         phase     = PH_START;
         nib       = '0;
         half      = 1'b0;
         count     = '0;
         rec_len   = '0;
         rec_type  = '0;
         sum       = '0;
         low_addr  = '0;
         high_addr = '0;
         ext_word  = '0;
         cur_addr  = '0;
         last_addr = '0;
         seen_eof  = 1'b0;
         fails     = 0;
      endfunction

      function logic [4:0] nibble_of(logic [7:0] c);
         logic [7:0] d;
         if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
         else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
         else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
         else return 5'h10;
         return {1'b0, d[3:0]};
      endfunction

      function err_type take_byte(logic [7:0] b);
         logic [31:0] hole;
         case (phase)
            PH_LEN: begin
               rec_len = b;
               count   = '0;
               phase   = PH_ADDR;
            end
            PH_ADDR: begin
               if (count == 0) begin
                  low_addr = {b, 8'h00};
                  count    = 8'd1;
               end else begin
                  low_addr[7:0] = b;
                  phase         = PH_TYPE;
               end
            end
            PH_TYPE: begin
               rec_type = b;
               count    = '0;
               ext_word = '0;
               if (b == REC_DATA) begin
                  cur_addr = {high_addr, low_addr};
                  if (cur_addr < last_addr) return ERR_BACKWARD;
               end
               phase = (rec_len != 0) ? PH_DATA : PH_CSUM;
            end
            PH_DATA: begin
               if (rec_type == REC_DATA) begin
                  hole                  = cur_addr - last_addr;
                  data_out              = '0;
                  data_out.kind         = KIND_DATA;
                  data_out.data_byte    = b;
                  data_out.byte_address = cur_addr;
                  data_out.fill_count   = (last_addr != 0 && hole > 1) ? hole - 1 : 32'd0;
                  data_hit              = 1'b1;
                  last_addr             = cur_addr;
                  cur_addr              = cur_addr + 1;
               end else if (rec_type == REC_EXT) begin
                  if (count == 0) ext_word = {b, 8'h00};
                  else if (count == 1) ext_word[7:0] = b;
               end
               count = count + 8'd1;
               if (count == rec_len) phase = PH_CSUM;
            end
            PH_CSUM: begin
               phase = PH_EOL;
               if (check_on && sum != 0) return ERR_CHECKSUM;
               case (rec_type)
                  REC_DATA: ;
                  REC_EOF: begin
                     if (seen_eof) return ERR_DUP_EOF;
                     seen_eof = 1'b1;
                  end
                  REC_EXT: begin
                     high_addr = ext_word;
                     cur_addr  = {high_addr, low_addr};
                  end
                  REC_SYM: cur_addr = {high_addr, low_addr};
                  default: if (!seen_eof) return ERR_TYPE;
               endcase
            end
            default: ;
         endcase
         return ERR_NONE;
      endfunction

      function void take_char(req_type it);
         err_type    err;
         logic [4:0] v;
         logic [7:0] b;
         rsp_type    res;
         err      = ERR_NONE;
         data_hit = 1'b0;
         if (phase == PH_HALT) return;
         if (phase == PH_START || phase == PH_EOL) begin
            if (it.ch == CHAR_COLON) begin
               phase = PH_LEN;
               half  = 1'b0;
               count = '0;
               sum   = '0;
            end else if (!(phase == PH_EOL && (it.ch == CHAR_LF || it.ch == CHAR_CR))) begin
               err = ERR_START;
            end
         end else begin
            v = nibble_of(it.ch);
            if (v[4]) begin
               err = ERR_NONHEX;
            end else if (!half) begin
               nib  = v[3:0];
               half = 1'b1;
            end else begin
               b    = {nib, v[3:0]};
               half = 1'b0;
               sum  = sum + b;
               err  = take_byte(b);
            end
         end
         res = '0;
         if (err == ERR_NONE && it.end_of_input) begin
            if (phase != PH_EOL) begin
               err = ERR_INCOMPLETE;
            end else if (!seen_eof) begin
               err = ERR_NO_EOF;
            end else begin
               res.kind = KIND_OK;
               pending_results.push_back(res);
               phase = PH_HALT;
               return;
            end
         end
         if (err != ERR_NONE) begin
            res.kind       = KIND_ERROR;
            res.error_code = err;
            pending_results.push_back(res);
            phase = PH_HALT;
            return;
         end
         if (data_hit) pending_results.push_back(data_out);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
            fails++;
         end
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item kind %0d byte %h addr %h fill %h code %0d",
                     $time, got.kind, got.data_byte, got.byte_address, got.fill_count,
                     got.error_code);
            fails++;
            return;
         end
         want = pending_results.pop_front();
         compare("kind", want.kind, got.kind);
         compare("data_byte", want.data_byte, got.data_byte);
         compare("byte_address", want.byte_address, got.byte_address);
         compare("fill_count", want.fill_count, got.fill_count);
         compare("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_item    = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_item;
   logic    csr_wr_en   = 1'b0;
   logic    csr_wr_data = 1'b0;

   hex_decoder  decoder = new();
   req_type     char_q[$];
   int unsigned sent_chars  = 0;
   int unsigned send_idle   = 0;
   int unsigned rsp_idle    = 0;
   int unsigned cycle_count = 0;
   ending_type  ending;

   intel_hex_record_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) decoder.match_result(rsp_item);
      rsp_ready <= ($urandom_range(99) >= rsp_idle);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_intel_hex_record_parser: errors");
         $finish;
      end
   end

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + n;
      return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
   endfunction

   function automatic void push_char(logic [7:0] c);
      req_type it;
      it.ch           = c;
      it.end_of_input = 1'b0;
      char_q.push_back(it);
   endfunction

   function automatic void push_byte(logic [7:0] b);
      push_char(hex_char(b[7:4]));
      push_char(hex_char(b[3:0]));
   endfunction

   function automatic void mark_end();
      req_type it;
      it              = char_q.pop_back();
      it.end_of_input = 1'b1;
      char_q.push_back(it);
   endfunction

   function automatic byte_list random_body(int n);
      byte_list   b;
      logic [7:0] v;
      repeat (n) begin
         v = 8'($urandom);
         b.push_back(v);
      end
      return b;
   endfunction

   function automatic void add_record(logic [7:0] rtype, logic [15:0] addr,
                                      byte_list body, bit bad_sum);
      logic [7:0] sum;
      logic [7:0] n;
      logic [7:0] flip;
      n   = 8'(body.size());
      sum = n + addr[15:8] + addr[7:0] + rtype;
      push_char(CHAR_COLON);
      push_byte(n);
      push_byte(addr[15:8]);
      push_byte(addr[7:0]);
      push_byte(rtype);
      foreach (body[i]) begin
         sum = sum + body[i];
         push_byte(body[i]);
      end
      sum = -sum;
      if (bad_sum) begin
         flip = 8'($urandom_range(1, 255));
         sum  = sum ^ flip;
      end
      push_byte(sum);
   endfunction

   function automatic void add_separators();
      repeat ($urandom_range(2)) push_char($urandom_range(1) ? CHAR_CR : CHAR_LF);
   endfunction

   function automatic logic [7:0] unknown_type();
      logic [7:0] t;
      do t = 8'($urandom);
      while (t == REC_DATA || t == REC_EOF || t == REC_EXT || t == REC_SYM);
      return t;
   endfunction

   function automatic int short_len();
      return ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 16);
   endfunction

   function automatic logic [31:0] pick_target();
      logic [31:0] last;
      logic [15:0] hi;
      int unsigned r;
      last = decoder.last_addr;
      hi   = last[31:16] + 16'd1;
      r    = $urandom_range(99);
      if (r < 5) return last;
      if (r < 55) return last + 1;
      if (r < 80) return last + $urandom_range(2, 64);
      if (r < 90) return {hi, 16'hfff8};
      return last + $urandom_range(65, 32'h0002_0000);
   endfunction

   function automatic void steer_high(logic [31:0] target, bit bad_sum);
      byte_list w;
      if (target[31:16] != decoder.high_addr) begin
         w.push_back(target[31:24]);
         w.push_back(target[23:16]);
         add_record(REC_EXT, 16'h0000, w, bad_sum);
         add_separators();
      end
   endfunction

   function automatic void add_data(logic [31:0] target, int len, bit bad_sum);
      steer_high(target, bad_sum);
      add_record(REC_DATA, target[15:0], random_body(len), bad_sum);
   endfunction

   task automatic drive_char(req_type it);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decoder.take_char(it);
      sent_chars++;
   endtask

   task automatic flush_chars();
      foreach (char_q[i]) drive_char(char_q[i]);
      char_q.delete();
   endtask

   task automatic drain(int tail);
      req_valid <= 1'b0;
      do @(posedge clock);
      while (decoder.pending_results.size() != 0);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_check(bit v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en        <= 1'b0;
      decoder.check_on  = v;
   endtask

   task automatic directed_records();
      byte_list w;
      w.push_back(8'hff);
      w.push_back(8'hff);
      add_record(REC_EXT, 16'h0000, w, 1'b0);
      add_separators();
      add_record(REC_DATA, 16'hfffe, random_body(4), 1'b0);
      w.delete();
      w.push_back(8'h00);
      w.push_back(8'h00);
      w.push_back(8'h7f);
      add_record(REC_EXT, 16'h0000, w, 1'b0);
      add_record(REC_DATA, 16'h0010, random_body(2), 1'b0);
      w.delete();
      w.push_back(8'h12);
      add_record(REC_EXT, 16'h0000, w, 1'b0);
      add_separators();
      add_record(REC_DATA, 16'h0000, random_body(0), 1'b0);
      add_record(REC_DATA, 16'h0000, random_body(1), 1'b0);
      add_record(REC_SYM, 16'h0040, random_body(3), 1'b0);
      if (ending != FIN_TYPE && ending != FIN_NO_EOF) begin
         w.delete();
         add_record(REC_EOF, 16'h0000, w, 1'b0);
         add_record(unknown_type(), 16'h0000, random_body(1), 1'b0);
      end
      flush_chars();
   endtask

   task automatic random_records(int unsigned budget);
      int unsigned start;
      int unsigned r;
      bit          bad;
      logic [15:0] addr;
      start = sent_chars;
      while (sent_chars - start < budget) begin
         r    = $urandom_range(99);
         bad  = !decoder.check_on && ($urandom_range(3) == 0);
         addr = 16'($urandom);
         add_separators();
         if (r < 62) begin
            add_data(pick_target(), short_len(), bad);
         end else if (r < 74) begin
            add_record(REC_EXT, addr,
                       random_body(($urandom_range(9) < 7) ? 2 : $urandom_range(4)), bad);
         end else if (r < 84) begin
            add_record(REC_SYM, addr, random_body($urandom_range(8)), bad);
         end else if (r < 92 && decoder.seen_eof) begin
            add_record(unknown_type(), addr, random_body($urandom_range(6)), bad);
         end else begin
            add_data(pick_target(), short_len(), bad);
         end
         flush_chars();
      end
   endtask

   task automatic end_file();
      req_type     it;
      logic [7:0]  c;
      logic [4:0]  v;
      logic [31:0] target;
      logic [31:0] back;
      int          idx0;
      int          k;
      add_separators();
      case (ending)
         FIN_OK, FIN_NO_EOF: begin
            if ($urandom_range(1)) add_data(pick_target(), short_len(), 1'b0);
            else push_char(CHAR_LF);
            mark_end();
         end
         FIN_START: begin
            do c = 8'($urandom);
            while (c == CHAR_COLON || c == CHAR_LF || c == CHAR_CR);
            push_char(c);
            if ($urandom_range(1)) mark_end();
         end
         FIN_INCOMPLETE: begin
            target = pick_target();
            steer_high(target, 1'b0);
            idx0 = char_q.size();
            add_record(REC_DATA, target[15:0], random_body($urandom_range(8)), 1'b0);
            k = $urandom_range(idx0, char_q.size() - 2);
            while (char_q.size() > k + 1) void'(char_q.pop_back());
            mark_end();
         end
         FIN_CHECKSUM: add_data(pick_target(), short_len(), 1'b1);
         FIN_BACKWARD: begin
            back   = (decoder.last_addr < 4096) ? decoder.last_addr : 32'd4096;
            target = decoder.last_addr - $urandom_range(1, back);
            add_data(target, $urandom_range(4), 1'b0);
         end
         FIN_DUP_EOF: add_record(REC_EOF, 16'h0000, random_body(0), 1'b0);
         FIN_TYPE: add_record(unknown_type(), 16'($urandom), random_body($urandom_range(4)),
                              1'b0);
         FIN_NONHEX: begin
            target = pick_target();
            steer_high(target, 1'b0);
            idx0 = char_q.size();
            add_record(REC_DATA, target[15:0], random_body(short_len()), 1'b0);
            k = $urandom_range(idx0 + 1, char_q.size() - 1);
            do begin
               c = 8'($urandom);
               v = decoder.nibble_of(c);
            end while (!v[4]);
            it.ch           = c;
            it.end_of_input = 1'($urandom_range(1));
            char_q[k]       = it;
         end
         default: ;
      endcase
      repeat (24) begin
         it.ch           = 8'($urandom);
         it.end_of_input = 1'($urandom_range(1));
         char_q.push_back(it);
      end
      flush_chars();
   endtask

   initial begin
      ending = ending_type'($urandom_range(FIN_NONHEX));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle = 7;
      rsp_idle  = 63;
      write_check(1'b1);
      directed_records();
      random_records(520);

      drain(8);
      send_idle = 63;
      rsp_idle  = 7;
      write_check(1'b0);
      add_separators();
      add_data(pick_target(), 255, 1'b0);
      flush_chars();
      random_records(100);

      drain(8);
      send_idle = 0;
      rsp_idle  = 0;
      write_check(1'b1);
      random_records(560);
      end_file();

      drain(16);
      if (decoder.fails == 0) $display("tb_intel_hex_record_parser: clean");
      else $display("tb_intel_hex_record_parser: errors");
      $finish;
   end

endmodule

// ===== intel_hex_record_parser.f =====
+incdir+sv
sv/ihex_pkg.sv
sv/ihex_parse_core.sv
sv/intel_hex_record_parser.sv
tb/sv/tb_intel_hex_record_parser.sv
